// ===== design/rmq_pkg.sv =====
`default_nettype none
package rmq_pkg;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int FRACTION_BITS = 14;
    localparam int QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] rot_r1c1;
        logic signed [SAMPLE_WIDTH-1:0] rot_r1c2;
        logic signed [SAMPLE_WIDTH-1:0] rot_r1c3;
        logic signed [SAMPLE_WIDTH-1:0] rot_r2c1;
        logic signed [SAMPLE_WIDTH-1:0] rot_r2c2;
        logic signed [SAMPLE_WIDTH-1:0] rot_r2c3;
        logic signed [SAMPLE_WIDTH-1:0] rot_r3c1;
        logic signed [SAMPLE_WIDTH-1:0] rot_r3c2;
        logic signed [SAMPLE_WIDTH-1:0] rot_r3c3;
    } rmq_in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] quat_w;
        logic signed [SAMPLE_WIDTH-1:0] quat_x;
        logic signed [SAMPLE_WIDTH-1:0] quat_y;
        logic signed [SAMPLE_WIDTH-1:0] quat_z;
        logic                           degenerate;
    } rmq_out_t;

    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } rmq_branch_t;
endpackage
`default_nettype wire

// ===== design/rmq_front.sv =====
`default_nettype none
// picks the branch, forms the root argument and the three numerators
module rmq_front #(
    parameter int SW = rmq_pkg::SAMPLE_WIDTH,
    parameter int FB = rmq_pkg::FRACTION_BITS,
    parameter int AW = SW + 3
) (
    input  wire  logic                   aclk,
    input  wire  logic                   aresetn,
    input  wire  logic [9*SW-1:0]        in_data,
    input  wire  logic                   in_valid,
    output logic                         in_ready,
    output logic                         out_valid,
    input  wire  logic                   out_ready,
    output logic [1:0]                   out_branch,
    output logic                         out_neg,
    output logic [AW-1:0]                out_arg,
    output logic signed [AW-1:0]         out_n0,
    output logic signed [AW-1:0]         out_n1,
    output logic signed [AW-1:0]         out_n2
);
    logic signed [AW-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
    logic signed [AW-1:0] tr, arg;
    logic signed [AW-1:0] n0, n1, n2;
    logic [1:0]           br;
    logic                 valid_reg;
    logic [1:0]           br_reg;
    logic                 neg_reg;
    logic [AW-1:0]        arg_reg;
    logic signed [AW-1:0] n0_reg, n1_reg, n2_reg;
    localparam logic signed [AW-1:0] ONE = AW'(1) <<< FB;

    always_comb begin
        m11 = AW'($signed(in_data[9*SW-1 -: SW]));
        m12 = AW'($signed(in_data[8*SW-1 -: SW]));
        m13 = AW'($signed(in_data[7*SW-1 -: SW]));
        m21 = AW'($signed(in_data[6*SW-1 -: SW]));
        m22 = AW'($signed(in_data[5*SW-1 -: SW]));
        m23 = AW'($signed(in_data[4*SW-1 -: SW]));
        m31 = AW'($signed(in_data[3*SW-1 -: SW]));
        m32 = AW'($signed(in_data[2*SW-1 -: SW]));
        m33 = AW'($signed(in_data[SW-1 -: SW]));
        tr  = m11 + m22 + m33;
        if (tr > 0) begin
            br = rmq_pkg::BR_W;
            arg = tr + ONE;
            n0 = m32 - m23; n1 = m13 - m31; n2 = m21 - m12;
        end else if (m11 > m22 && m11 > m33) begin
            br = rmq_pkg::BR_X;
            arg = ONE + m11 - m22 - m33;
            n0 = m32 - m23; n1 = m12 + m21; n2 = m13 + m31;
        end else if (m22 > m33) begin
            br = rmq_pkg::BR_Y;
            arg = ONE + m22 - m11 - m33;
            n0 = m13 - m31; n1 = m12 + m21; n2 = m23 + m32;
        end else begin
            br = rmq_pkg::BR_Z;
            arg = ONE + m33 - m11 - m22;
            n0 = m21 - m12; n1 = m13 + m31; n2 = m23 + m32;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_branch = br_reg;
    assign out_neg = neg_reg;
    assign out_arg = arg_reg;
    assign out_n0 = n0_reg;
    assign out_n1 = n1_reg;
    assign out_n2 = n2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            br_reg  <= br;
            neg_reg <= arg < 0;
            arg_reg <= (arg < 0) ? '0 : arg;
            n0_reg  <= n0;
            n1_reg  <= n1;
            n2_reg  <= n2;
        end
    end
endmodule
`default_nettype wire

// ===== design/rmq_fifo.sv =====
`default_nettype none
// short queue between front and back, registered flops
module rmq_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = rmq_pkg::QUEUE_DEPTH
) (
    input  wire  logic         aclk,
    input  wire  logic         aresetn,
    input  wire  logic [W-1:0] wr_data,
    input  wire  logic         wr_valid,
    output logic               wr_ready,
    output logic [W-1:0]       rd_data,
    output logic               rd_valid,
    input  wire  logic         rd_ready
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    logic          wr, rd;

    assign wr_ready = cnt_reg != (PW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) begin
                wp_reg <= (wp_reg == PW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd) begin
                rp_reg <= (rp_reg == PW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(wr) - (PW+1)'(rd);
        end
        if (wr) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (PW+1)'(DEPTH)) else $error("queue overflow");
    a_no_wr_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == (PW+1)'(DEPTH) && !rd) |=> cnt_reg == (PW+1)'(DEPTH))
        else $error("queue count lost");
endmodule
`default_nettype wire

// ===== design/rmq_back.sv =====
`default_nettype none
// pipelined square root then three pipelined restoring dividers
module rmq_back #(
    parameter int SW = rmq_pkg::SAMPLE_WIDTH,
    parameter int FB = rmq_pkg::FRACTION_BITS,
    parameter int AW = SW + 3
) (
    input  wire  logic                   aclk,
    input  wire  logic                   aresetn,
    input  wire  logic                   in_valid,
    output logic                         in_ready,
    input  wire  logic [1:0]             in_branch,
    input  wire  logic                   in_neg,
    input  wire  logic [AW-1:0]          in_arg,
    input  wire  logic signed [AW-1:0]   in_n0,
    input  wire  logic signed [AW-1:0]   in_n1,
    input  wire  logic signed [AW-1:0]   in_n2,
    output logic                         out_valid,
    input  wire  logic                   out_ready,
    output rmq_pkg::rmq_out_t            out_data
);
    // radicand arg<<FB padded to an even width, root has RW bits
    localparam int RW = (AW + FB + 1) / 2;
    localparam int VW = 2 * RW;
    localparam int SQ = RW;              // one root bit per stage
    localparam int DW = AW + FB;         // dividend width (magnitude)
    localparam int DS = DW;              // one quotient bit per stage
    localparam int NS = SQ + DS;
    localparam int DV = RW + 1;          // divisor width
    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct packed {
        logic [1:0]     br;
        logic           neg;
        logic [2:0]     sgn;
        logic [AW-1:0]  m0, m1, m2;
    } side_t;

    logic                adv;
    logic [NS-1:0]       v_reg;
    side_t               sd_reg   [NS];
    logic [VW-1:0]       rem_reg  [SQ];
    logic [RW-1:0]       root_reg [SQ];
    logic [VW-1:0]       rad_reg  [SQ];
    logic [RW-1:0]       r_reg    [DS];
    logic [DW-1:0]       dq_reg   [DS][3];
    logic [DV:0]         dr_reg   [DS][3];
    logic                ov_reg;
    rmq_pkg::rmq_out_t   res_reg;

    assign adv = !ov_reg || out_ready;
    assign in_ready = adv;
    assign out_valid = ov_reg;
    assign out_data = res_reg;

    function automatic logic signed [SW-1:0] sat(input logic sgn,
                                                  input logic [DW-1:0] mag);
        logic signed [DW:0] v;
        begin
            v = sgn ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            if (v > $signed((DW+1)'(SMAX))) sat = SMAX;
            else if (v < $signed({{(DW+1-SW){1'b1}}, SMIN})) sat = SMIN;
            else sat = v[SW-1:0];
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end else if (adv) begin
            v_reg  <= {v_reg[NS-2:0], in_valid};
            ov_reg <= v_reg[NS-1];
        end
    end

    // datapath, stalls as a whole
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NS; i++) begin
                if (i == 0) begin
                    sd_reg[0].br  <= in_branch;
                    sd_reg[0].neg <= in_neg;
                    sd_reg[0].sgn <= {in_n2[AW-1], in_n1[AW-1], in_n0[AW-1]};
                    sd_reg[0].m0  <= in_n0[AW-1] ? AW'(-in_n0) : in_n0;
                    sd_reg[0].m1  <= in_n1[AW-1] ? AW'(-in_n1) : in_n1;
                    sd_reg[0].m2  <= in_n2[AW-1] ? AW'(-in_n2) : in_n2;
                end else begin
                    sd_reg[i] <= sd_reg[i-1];
                end
            end
            // digit-by-digit square root, msb first
            for (int i = 0; i < SQ; i++) begin
                logic [VW-1:0]  rem, rad;
                logic [RW-1:0]  root;
                logic [VW+1:0]  trial, cur;
                if (i == 0) begin
                    rem = '0; root = '0; rad = VW'(in_arg) << FB;
                end else begin
                    rem = rem_reg[i-1]; root = root_reg[i-1]; rad = rad_reg[i-1];
                end
                cur   = {rem, rad[VW-1 -: 2]} ;
                trial = (VW+2)'({root, 2'b01});
                if (cur >= trial) begin
                    rem_reg[i]  <= VW'(cur - trial);
                    root_reg[i] <= {root[RW-2:0], 1'b1};
                end else begin
                    rem_reg[i]  <= VW'(cur);
                    root_reg[i] <= {root[RW-2:0], 1'b0};
                end
                rad_reg[i] <= rad << 2;
            end
            // restoring divide of (mag<<FB) by 2r
            for (int i = 0; i < DS; i++) begin
                logic [RW-1:0] r;
                r = (i == 0) ? root_reg[SQ-1] : r_reg[i-1];
                r_reg[i] <= r;
                for (int k = 0; k < 3; k++) begin
                    logic [DW-1:0] dq;
                    logic [DV:0]   dr, t;
                    if (i == 0) begin
                        dr = '0;
                        case (k)
                            0: dq = DW'(sd_reg[SQ-1].m0) << FB;
                            1: dq = DW'(sd_reg[SQ-1].m1) << FB;
                            default: dq = DW'(sd_reg[SQ-1].m2) << FB;
                        endcase
                    end else begin
                        dq = dq_reg[i-1][k]; dr = dr_reg[i-1][k];
                    end
                    t = {dr[DV-1:0], dq[DW-1]};
                    if (t >= (DV+1)'({r, 1'b0})) begin
                        dr_reg[i][k] <= t - (DV+1)'({r, 1'b0});
                        dq_reg[i][k] <= {dq[DW-2:0], 1'b1};
                    end else begin
                        dr_reg[i][k] <= t;
                        dq_reg[i][k] <= {dq[DW-2:0], 1'b0};
                    end
                end
            end
            // assemble
            begin
                side_t sd;
                logic [RW-1:0] r;
                logic signed [SW-1:0] own, a, b, c;
                sd = sd_reg[NS-1];
                r  = r_reg[DS-1];
                own = sat(1'b0, DW'(r >> 1));
                a = sat(sd.sgn[0], dq_reg[DS-1][0]);
                b = sat(sd.sgn[1], dq_reg[DS-1][1]);
                c = sat(sd.sgn[2], dq_reg[DS-1][2]);
                res_reg.degenerate <= sd.neg || (r == '0);
                if (r == '0) begin
                    res_reg.quat_w <= '0; res_reg.quat_x <= '0;
                    res_reg.quat_y <= '0; res_reg.quat_z <= '0;
                end else begin
                    case (sd.br)
                        rmq_pkg::BR_W: begin
                            res_reg.quat_w <= own; res_reg.quat_x <= a;
                            res_reg.quat_y <= b;   res_reg.quat_z <= c;
                        end
                        rmq_pkg::BR_X: begin
                            res_reg.quat_w <= a;   res_reg.quat_x <= own;
                            res_reg.quat_y <= b;   res_reg.quat_z <= c;
                        end
                        rmq_pkg::BR_Y: begin
                            res_reg.quat_w <= a;   res_reg.quat_x <= b;
                            res_reg.quat_y <= own; res_reg.quat_z <= c;
                        end
                        default: begin
                            res_reg.quat_w <= a;   res_reg.quat_x <= b;
                            res_reg.quat_y <= c;   res_reg.quat_z <= own;
                        end
                    endcase
                end
            end
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && !out_ready) |=> ov_reg) else $error("result dropped");
    a_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && v_reg[NS-1]) |=> ov_reg) else $error("pipe item lost");
endmodule
`default_nettype wire

// ===== design/rotation_matrix_to_quaternion.sv =====
`default_nettype none
// Rotation matrix to quaternion (Shepperd's method) in signed Q.FRACTION_BITS.
// One matrix is taken per cycle unless the output stalls. A front stage picks
// the branch and forms the root argument and numerators; a two-entry queue
// feeds a back pipeline of one stage per root bit and one stage per quotient
// bit (three dividers in lanes). Degenerate is set for a negative root
// argument or a zero root.
module rotation_matrix_to_quaternion #(
    parameter int SAMPLE_WIDTH  = rmq_pkg::SAMPLE_WIDTH,
    parameter int FRACTION_BITS = rmq_pkg::FRACTION_BITS
) (
    input  wire  logic               aclk,
    input  wire  logic               aresetn,
    input  wire  rmq_pkg::rmq_in_t   s_data,
    input  wire  logic               s_valid,
    output logic                     s_ready,
    output rmq_pkg::rmq_out_t        m_data,
    output logic                     m_valid,
    input  wire  logic               m_ready
);
    localparam int AW = SAMPLE_WIDTH + 3;
    localparam int QW = 2 + 1 + 4 * AW;

    logic                 f_valid, f_ready, b_valid, b_ready;
    logic [1:0]           f_br;
    logic                 f_neg;
    logic [AW-1:0]        f_arg;
    logic signed [AW-1:0] f_n0, f_n1, f_n2;
    logic [QW-1:0]        q_in, q_out;

    rmq_front #(.SW(SAMPLE_WIDTH), .FB(FRACTION_BITS), .AW(AW)) u_front (
        .aclk, .aresetn, .in_data(s_data), .in_valid(s_valid), .in_ready(s_ready),
        .out_valid(f_valid), .out_ready(f_ready), .out_branch(f_br),
        .out_neg(f_neg), .out_arg(f_arg), .out_n0(f_n0), .out_n1(f_n1),
        .out_n2(f_n2)
    );

    assign q_in = {f_br, f_neg, f_arg, f_n0, f_n1, f_n2};

    rmq_fifo #(.W(QW), .DEPTH(rmq_pkg::QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn, .wr_data(q_in), .wr_valid(f_valid), .wr_ready(f_ready),
        .rd_data(q_out), .rd_valid(b_valid), .rd_ready(b_ready)
    );

    rmq_back #(.SW(SAMPLE_WIDTH), .FB(FRACTION_BITS), .AW(AW)) u_back (
        .aclk, .aresetn, .in_valid(b_valid), .in_ready(b_ready),
        .in_branch(q_out[QW-1 -: 2]), .in_neg(q_out[4*AW]),
        .in_arg(q_out[4*AW-1 -: AW]), .in_n0(q_out[3*AW-1 -: AW]),
        .in_n1(q_out[2*AW-1 -: AW]), .in_n2(q_out[AW-1:0]),
        .out_valid(m_valid), .out_ready(m_ready), .out_data(m_data)
    );

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data)) else $error("result changed");
endmodule
`default_nettype wire
